>>> hdl/s4fma_pkg.sv
// Package with shared types and constants for the four-lane truncating float unit.
`default_nettype none
package s4fma_pkg;
  localparam int LANES = 4;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_FMA  = 3'd3,
    OP_FMS  = 3'd4,
    OP_FNMS = 3'd5
  } opcode_t;

  // Product or operand term: value = mag * 2^ex.
  typedef struct packed {
    logic              neg;
    logic [47:0]       mag;
    logic signed [10:0] ex;
  } prod_t;

  typedef struct packed {
    logic              neg;
    logic [23:0]       mag;
    logic signed [10:0] ex;
  } addend_t;

  // Aligned operands ready for the add.
  typedef struct packed {
    logic              big_neg;
    logic              sub;
    logic [63:0]       big_mag;
    logic [63:0]       sml_mag;
    logic signed [10:0] ex;
  } aligned_t;

  typedef struct packed {
    logic              neg;
    logic [63:0]       mag;
    logic signed [10:0] ex;
  } sum_t;
endpackage
`default_nettype wire

>>> hdl/s4fma_if.sv
// Valid/ready channel interface used by the input and output ports.
`default_nettype none
interface s4fma_if #(
  parameter int W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/s4fma_lane.sv
// One lane: decode and multiply, align, add, normalize and encode over four stages.
`default_nettype none
module s4fma_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  output logic [31:0]      word,
  output logic             ovf
);
  s4fma_pkg::prod_t     p1;
  s4fma_pkg::addend_t   c1;
  s4fma_pkg::aligned_t  al2;
  s4fma_pkg::sum_t      s3;
  logic [23:0] ma, mb, mc;
  logic signed [10:0] ea, eb, ec;
  logic na, nb, nc;
  s4fma_pkg::prod_t     x;
  s4fma_pkg::addend_t   y;

  always_comb begin
    ma = (a[30:23] == 8'd0) ? 24'd0 : {1'b1, a[22:0]};
    mb = (b[30:23] == 8'd0) ? 24'd0 : {1'b1, b[22:0]};
    mc = (c[30:23] == 8'd0) ? 24'd0 : {1'b1, c[22:0]};
    ea = $signed({3'd0, a[30:23]}) - 11'sd150;
    eb = $signed({3'd0, b[30:23]}) - 11'sd150;
    ec = $signed({3'd0, c[30:23]}) - 11'sd150;
    na = a[31];
    nb = b[31];
    nc = c[31];
    x = '0;
    y = '0;
    unique case (opcode)
      s4fma_pkg::OP_ADD, s4fma_pkg::OP_SUB: begin
        x.neg = na;
        x.mag = {24'd0, ma};
        x.ex = ea;
        y.neg = (opcode == s4fma_pkg::OP_SUB) ? ~nb : nb;
        y.mag = mb;
        y.ex = eb;
      end
      default: begin
        x.neg = (na ^ nb) ^ (opcode == s4fma_pkg::OP_FNMS);
        x.mag = ma * mb;
        x.ex = ea + eb;
        y.neg = (opcode == s4fma_pkg::OP_FMS) ? ~nc : nc;
        y.mag = (opcode == s4fma_pkg::OP_MUL) ? 24'd0 : mc;
        y.ex = ec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= x;
      c1 <= y;
    end
  end

  // Stage 2: place both terms with top bit at 61 and align the smaller one.
  logic [63:0] xm, ym, bm, sm, sh, lost;
  logic signed [10:0] xe, ye, be, se;
  logic [11:0] d;
  logic xbig;
  logic [5:0] xlz;
  s4fma_pkg::aligned_t al;

  always_comb begin
    xlz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p1.mag[i]) xlz = 6'(61 - i);
    end
    xm = {16'd0, p1.mag} << xlz;
    xe = p1.ex - 11'(xlz);
    ym = {16'd0, c1.mag, 24'd0} << 14;
    ye = c1.ex - 11'sd38;
    xbig = (xe > ye) || ((xe == ye) && (xm >= ym));
    bm = xbig ? xm : ym;
    sm = xbig ? ym : xm;
    be = xbig ? xe : ye;
    se = xbig ? ye : xe;
    d = 12'(be - se);
    if (d >= 12'd62) begin
      sh = 64'd1;
    end else begin
      sh = sm >> d[5:0];
      lost = sm & ((64'd1 << d[5:0]) - 64'd1);
      sh = sh | {63'd0, lost != 64'd0};
    end
    lost = '0;
    al.big_neg = xbig ? p1.neg : c1.neg;
    al.sub = p1.neg ^ c1.neg;
    al.big_mag = bm;
    al.sml_mag = sh;
    al.ex = be;
    if (p1.mag == 48'd0) begin
      al.big_neg = c1.neg;
      al.sub = 1'b0;
      al.big_mag = ym;
      al.sml_mag = 64'd0;
      al.ex = ye;
    end else if (c1.mag == 24'd0) begin
      al.big_neg = p1.neg;
      al.sub = 1'b0;
      al.big_mag = xm;
      al.sml_mag = 64'd0;
      al.ex = xe;
    end
  end

  always_ff @(posedge clk) begin
    if (en) al2 <= al;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.neg <= al2.big_neg;
      s3.mag <= al2.sub ? al2.big_mag - al2.sml_mag : al2.big_mag + al2.sml_mag;
      s3.ex <= al2.ex;
    end
  end

  // Stage 4: find the leading one and encode with truncation.
  logic [5:0] p;
  logic [63:0] m;
  logic signed [11:0] e;
  logic [31:0] w;
  logic o;

  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s3.mag[i]) p = 6'(i);
    end
    m = (p >= 6'd23) ? (s3.mag >> (p - 6'd23)) : (s3.mag << (6'd23 - p));
    e = 12'(s3.ex) + 12'(p);
    w = 32'd0;
    o = 1'b0;
    if (s3.mag != 64'd0) begin
      if (e >= 12'sd128) begin
        o = 1'b1;
      end else if (e >= -12'sd126) begin
        w = {s3.neg, 8'(e + 12'sd127), m[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= w;
      ovf <= o;
    end
  end
endmodule
`default_nettype wire

>>> hdl/simd4_truncating_float_fma_top.sv
// Top level of the four-lane truncating float unit with valid/ready channels.
//   channel | direction | payload
//   in      | sink      | opcode, a_low..c_high
//   out     | source    | result_low, result_high, handled
// One transfer per cycle in while the pipeline advances; a result is offered after its input
// transfer has passed four register stages in each lane, the last one feeding the output.
// Valid and status bits travel beside the data.
// The whole pipeline advances only when the last stage is empty or taken, so a stall
// freezes every stage. rst clears the valid bits only and holds the input not ready.
`default_nettype none
module simd4_truncating_float_fma_top (
  input wire logic clk,
  input wire logic rst,
  s4fma_if.sink    in,
  s4fma_if.source  out
);
  localparam int DEPTH = 4;
  logic [2:0] opcode;
  logic [63:0] a_low, a_high, b_low, b_high, c_low, c_high;
  assign {opcode, a_low, a_high, b_low, b_high, c_low, c_high} = in.data;

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] okp;
  logic en, ok0;
  logic [127:0] av, bv, cv;
  logic [127:0] res;
  logic [3:0] ovf;

  assign en = ~vld[DEPTH-1] | out.ready;
  assign in.ready = en & ~rst;
  assign av = {a_high, a_low};
  assign bv = {b_high, b_low};
  assign cv = {c_high, c_low};

  always_comb begin
    ok0 = opcode <= 3'(s4fma_pkg::OP_FNMS);
    for (int i = 0; i < s4fma_pkg::LANES; i++) begin
      if (av[32*i+23 +: 8] == 8'hFF || bv[32*i+23 +: 8] == 8'hFF ||
          (opcode >= 3'(s4fma_pkg::OP_FMA) && cv[32*i+23 +: 8] == 8'hFF)) ok0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) okp <= {okp[DEPTH-2:0], ok0};
  end

  for (genvar g = 0; g < s4fma_pkg::LANES; g++) begin : g_lane
    s4fma_lane u_lane (
      .clk(clk),
      .en(en),
      .opcode(opcode),
      .a(av[32*g +: 32]),
      .b(bv[32*g +: 32]),
      .c(cv[32*g +: 32]),
      .word(res[32*g +: 32]),
      .ovf(ovf[g])
    );
  end

  logic handled;
  assign handled = okp[DEPTH-1] & (ovf == 4'd0);
  assign out.valid = vld[DEPTH-1];
  assign out.data = handled ? {res[63:0], res[127:64], 1'b1} : 129'd0;
endmodule
`default_nettype wire
